// ===== src/dmsu_pkg.sv =====
// Shared types, widths and constants of the decaying-momentum SGD update unit.
`timescale 1ns / 1ps
package dmsu_pkg;

  localparam int IDX_W      = 12;
  localparam int VAL_W      = 32;
  localparam int RATE_W     = 16;
  localparam int SPAN_W     = 24;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int PROD_W     = RATE_W + SPAN_W;
  localparam int MUL_W      = RATE_W + 1 + VAL_W;
  localparam int DIV_CNT_W  = $clog2(RATE_W);

  localparam logic [SPAN_W-1:0] STEP_MAX = {SPAN_W{1'b1}};

  localparam logic [RATE_W-1:0] LR_RST         = 16'd655;
  localparam logic [RATE_W-1:0] BETA_START_RST = 16'd58982;
  localparam logic [RATE_W-1:0] BETA_END_RST   = 16'd0;
  localparam logic [SPAN_W-1:0] SPAN_RST       = 24'd1000;
  localparam logic [RATE_W-1:0] DECAY_RST      = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARNING_RATE = 3'd0,
    CFG_BETA_START    = 3'd1,
    CFG_BETA_END      = 3'd2,
    CFG_DECAY_SPAN    = 3'd3,
    CFG_DECAY_RATE    = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_STEP,
    S_SCALE,
    S_DIV,
    S_BETA,
    S_LOAD,
    S_MOMENTUM,
    S_ACCUM,
    S_RATE,
    S_FINISH
  } dmsu_state_t;

  typedef struct packed {
    logic clr_wr;
    logic capture;
    logic step_adv;
    logic scale;
    logic div_step;
    logic beta_load;
    logic mem_rd;
    logic mom_mul;
    logic mom_wr;
    logic rate_mul;
    logic out_load;
  } dmsu_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic at_end;
    logic div_last;
    logic out_free;
  } dmsu_status_t;

  // Clamp a 34-bit signed sum to the signed 32-bit range.
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [VAL_W+1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/decaying_momentum_sgd_update_unit.sv =====
// Top level of the decaying-momentum SGD update unit.
// Flow: without new_step a request runs the LOAD, MOMENTUM, ACCUM, RATE and FINISH
//   states; new_step adds STEP and SCALE and, short of the span, the radix-2 beta divider.
// Requests: one at a time, set by the single-port momentum memory read-modify-write and the
//   shared beta divider; a finished result waits in the output reg.
// Reset: synchronous, active low; then a clearing pass over all NUM_ELEMENTS entries zeroes
//   the momentum memory while in_stall stays high (config writes are still taken).
`timescale 1ns / 1ps
module decaying_momentum_sgd_update_unit #(
  parameter int NUM_ELEMENTS = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [dmsu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dmsu_pkg::CFG_DATA_W-1:0]    cfg_data,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [dmsu_pkg::IDX_W-1:0]         in_element_index,
  input  logic signed [dmsu_pkg::VAL_W-1:0]  in_param_value,
  input  logic signed [dmsu_pkg::VAL_W-1:0]  in_grad_value,
  input  logic                               in_new_step,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [dmsu_pkg::VAL_W-1:0]  out_updated_param,
  output logic [dmsu_pkg::IDX_W-1:0]         out_index
);
  import dmsu_pkg::*;

  dmsu_cmd_t    cmd;
  dmsu_status_t st;

  // Sequencer: owns the handshake on the request side and steps the datapath.
  dmsu_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_new_step (in_new_step),
    .in_stall    (in_stall),
    .st          (st),
    .cmd         (cmd)
  );

  // Datapath: registers, beta schedule, momentum memory and the result register.
  dmsu_datapath #(
    .NUM_ELEMENTS (NUM_ELEMENTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_element_index  (in_element_index),
    .in_param_value    (in_param_value),
    .in_grad_value     (in_grad_value),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_updated_param (out_updated_param),
    .out_index         (out_index)
  );

endmodule

// ===== src/dmsu_ctrl.sv =====
// Sequencer of the update unit: clearing pass, beta schedule and per-element update.
`timescale 1ns / 1ps
module dmsu_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_new_step,
  output logic                  in_stall,
  input  dmsu_pkg::dmsu_status_t st,
  output dmsu_pkg::dmsu_cmd_t    cmd
);
  import dmsu_pkg::*;

  dmsu_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:    if (st.clr_last) state_nxt = S_IDLE;
      S_IDLE:     if (in_valid) state_nxt = in_new_step ? S_STEP : S_LOAD;
      S_STEP:     state_nxt = S_SCALE;
      S_SCALE:    state_nxt = st.at_end ? S_LOAD : S_DIV;
      S_DIV:      if (st.div_last) state_nxt = S_BETA;
      S_BETA:     state_nxt = S_LOAD;
      S_LOAD:     state_nxt = S_MOMENTUM;
      S_MOMENTUM: state_nxt = S_ACCUM;
      S_ACCUM:    state_nxt = S_RATE;
      S_RATE:     state_nxt = S_FINISH;
      S_FINISH:   if (st.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_CLEAR:    cmd.clr_wr = 1'b1;
      S_IDLE:     cmd.capture = in_valid;
      S_STEP:     cmd.step_adv = 1'b1;
      S_SCALE: begin
        cmd.scale     = 1'b1;
        cmd.beta_load = st.at_end;
      end
      S_DIV:      cmd.div_step = 1'b1;
      S_BETA:     cmd.beta_load = 1'b1;
      S_LOAD:     cmd.mem_rd = 1'b1;
      S_MOMENTUM: cmd.mom_mul = 1'b1;
      S_ACCUM:    cmd.mom_wr = 1'b1;
      S_RATE:     cmd.rate_mul = 1'b1;
      S_FINISH:   cmd.out_load = st.out_free;
      default:    cmd = '0;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// ===== src/dmsu_datapath.sv =====
// Datapath of the update unit: config registers, step/beta logic, momentum memory, MACs.
`timescale 1ns / 1ps
module dmsu_datapath #(
  parameter int NUM_ELEMENTS = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  dmsu_pkg::dmsu_cmd_t                    cmd,
  output dmsu_pkg::dmsu_status_t                 st,
  input  logic                                   cfg_we,
  input  logic [dmsu_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dmsu_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [dmsu_pkg::IDX_W-1:0]             in_element_index,
  input  logic signed [dmsu_pkg::VAL_W-1:0]      in_param_value,
  input  logic signed [dmsu_pkg::VAL_W-1:0]      in_grad_value,
  input  logic                                   out_stall,
  output logic                                   out_valid,
  output logic signed [dmsu_pkg::VAL_W-1:0]      out_updated_param,
  output logic [dmsu_pkg::IDX_W-1:0]             out_index
);
  import dmsu_pkg::*;

  localparam int AW = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_ELEMENTS - 1);

  // Configuration
  logic [RATE_W-1:0] lr_r, beta_start_r, beta_end_r, decay_r;
  logic [SPAN_W-1:0] span_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r         <= LR_RST;
      beta_start_r <= BETA_START_RST;
      beta_end_r   <= BETA_END_RST;
      span_r       <= SPAN_RST;
      decay_r      <= DECAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEARNING_RATE: lr_r         <= cfg_data[RATE_W-1:0];
        CFG_BETA_START:    beta_start_r <= cfg_data[RATE_W-1:0];
        CFG_BETA_END:      beta_end_r   <= cfg_data[RATE_W-1:0];
        CFG_DECAY_SPAN:    span_r       <= cfg_data[SPAN_W-1:0];
        CFG_DECAY_RATE:    decay_r      <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Captured request
  logic [IDX_W-1:0]        idx_r;
  logic signed [VAL_W-1:0] param_r, grad_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r   <= in_element_index;
      param_r <= in_param_value;
      grad_r  <= in_grad_value;
    end
  end

  // Step counter and beta schedule
  logic [SPAN_W-1:0] step_r;
  logic [RATE_W-1:0] beta_r;
  logic              beta_down;
  logic [RATE_W-1:0] beta_diff;
  logic [PROD_W-1:0] scale_prod;
  logic [SPAN_W-1:0] rem_r, rem_nxt;
  logic [RATE_W-1:0] q_r, q_nxt;
  logic [SPAN_W:0]   trial;
  logic              trial_ge;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  assign beta_down  = (beta_start_r >= beta_end_r);
  assign beta_diff  = beta_down ? (beta_start_r - beta_end_r) : (beta_end_r - beta_start_r);
  assign scale_prod = PROD_W'(beta_diff) * PROD_W'(step_r);

  // Quotient is below 2^16 since step < span, so the top bits start as the remainder.
  assign trial    = {rem_r, q_r[RATE_W-1]};
  assign trial_ge = (trial >= {1'b0, span_r});
  assign rem_nxt  = trial_ge ? SPAN_W'(trial - {1'b0, span_r}) : trial[SPAN_W-1:0];
  assign q_nxt    = {q_r[RATE_W-2:0], trial_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      beta_r <= BETA_START_RST;
    end else begin
      if (cmd.step_adv && (step_r != STEP_MAX)) begin
        step_r <= step_r + 1'b1;
      end
      if (cmd.beta_load) begin
        if (st.at_end) begin
          beta_r <= beta_end_r;
        end else if (beta_down) begin
          beta_r <= beta_start_r - q_r;
        end else begin
          beta_r <= beta_start_r + q_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      rem_r     <= scale_prod[PROD_W-1:RATE_W];
      q_r       <= scale_prod[RATE_W-1:0];
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      q_r       <= q_nxt;
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // Momentum memory and clearing sweep
  logic signed [VAL_W-1:0] mem [NUM_ELEMENTS];
  logic [AW-1:0]           clr_cnt_r;
  logic [IDX_W+AW-1:0]     idx_wide;
  logic [AW-1:0]           addr;
  logic                    in_range;
  logic signed [VAL_W-1:0] rd_data_r;

  assign idx_wide = {{AW{1'b0}}, idx_r};
  assign addr     = idx_wide[AW-1:0];
  assign in_range = (32'(idx_r) < 32'(NUM_ELEMENTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Arithmetic
  logic signed [MUL_W-1:0] decay_prod_r, beta_prod_r, lr_prod_r;
  logic signed [VAL_W-1:0] grad_eff_r, mom_r, mom_old, mom_nxt, res_nxt;

  assign mom_old = in_range ? rd_data_r : '0;
  assign mom_nxt = sat32({beta_prod_r[MUL_W-1], beta_prod_r[MUL_W-1:FRAC_W]}
                         + {{2{grad_eff_r[VAL_W-1]}}, grad_eff_r});
  assign res_nxt = sat32({{2{param_r[VAL_W-1]}}, param_r}
                         - {lr_prod_r[MUL_W-1], lr_prod_r[MUL_W-1:FRAC_W]});

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.mom_wr && in_range) begin
      mem[addr] <= mom_nxt;
    end
    if (cmd.mem_rd) begin
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      decay_prod_r <= $signed({1'b0, decay_r}) * param_r;
    end
    if (cmd.mom_mul) begin
      beta_prod_r <= $signed({1'b0, beta_r}) * mom_old;
      if (decay_r != '0) begin
        grad_eff_r <= sat32({{2{grad_r[VAL_W-1]}}, grad_r}
                            + {decay_prod_r[MUL_W-1], decay_prod_r[MUL_W-1:FRAC_W]});
      end else begin
        grad_eff_r <= grad_r;
      end
    end
    if (cmd.mom_wr) begin
      mom_r <= mom_nxt;
    end
    if (cmd.rate_mul) begin
      lr_prod_r <= $signed({1'b0, lr_r}) * mom_r;
    end
  end

  // Output register
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_param_r;
  logic [IDX_W-1:0]        out_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_param_r <= res_nxt;
      out_idx_r   <= idx_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_updated_param = out_param_r;
  assign out_index         = out_idx_r;

  assign st.clr_last = (clr_cnt_r == LAST_ADDR);
  assign st.at_end   = (span_r == '0) || (step_r >= span_r);
  assign st.div_last = (div_cnt_r == DIV_CNT_W'(RATE_W - 1));
  assign st.out_free = !out_valid_r || !out_stall;

endmodule

// ===== src/dmsu_checker.sv =====
// Port-level checks of the update unit and their binding to the top level.
`timescale 1ns / 1ps
module dmsu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_updated_param,
  input logic [11:0] out_index
);

  // A result held back by the receiver stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_updated_param) && $stable(out_index))
    else $error("stalled result changed or dropped");

  // Reset starts the memory clearing pass, so no request is taken right after it.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("request channel open right after reset");

  // One request at a time: an accepted request closes the input for the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in work");

  // A result never appears in the cycle right after a request is taken.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind decaying_momentum_sgd_update_unit dmsu_checker u_dmsu_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_updated_param (out_updated_param),
  .out_index         (out_index)
);

// ===== tb/tb_decaying_momentum_sgd_update_unit.sv =====
// Self-checking testbench of the decaying-momentum SGD update unit.
`timescale 1ns / 1ps
module tb_decaying_momentum_sgd_update_unit;
  import dmsu_pkg::*;

  localparam int NUM_ELEMENTS  = 4096;
  // Longest stretch without any accepted request or result before the run is abandoned.
  // It covers the clearing pass after reset, the long receiver hold-off, and the slowest
  // request with the longest random gaps on both sides, several times over.
  localparam int IDLE_LIMIT    = 20000;
  localparam int HOLD_CYCLES   = 300;
  // Wait at the end, after all results are back, so that a stray late result is still caught.
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 100;
  localparam int RANDOM_PHASES = 6;

  typedef struct {
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] param;
    logic signed [VAL_W-1:0] grad;
    logic                    new_step;
  } request_t;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        index;
  } update_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic [IDX_W-1:0]         in_element_index;
  logic signed [VAL_W-1:0]  in_param_value;
  logic signed [VAL_W-1:0]  in_grad_value;
  logic                     in_new_step;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [VAL_W-1:0]  out_updated_param;
  logic [IDX_W-1:0]         out_index;

  // Shadow copy of the register file and of the optimizer state.
  logic [RATE_W-1:0]        lr_rate;
  logic [RATE_W-1:0]        beta_from;
  logic [RATE_W-1:0]        beta_to;
  logic [SPAN_W-1:0]        span_steps;
  logic [RATE_W-1:0]        wd_rate;
  logic [SPAN_W-1:0]        sched_step;
  logic [RATE_W-1:0]        sched_beta;
  logic signed [VAL_W-1:0]  velocity [0:NUM_ELEMENTS-1];

  update_t                  pending_updates[$];
  int                       mismatch_count;

  // Knobs shared by the stimulus and the result-side stall generator.
  logic                     gaps_on;
  int                       stall_pct;
  logic                     hold_results;

  decaying_momentum_sgd_update_unit #(
    .NUM_ELEMENTS(NUM_ELEMENTS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_element_index  (in_element_index),
    .in_param_value    (in_param_value),
    .in_grad_value     (in_grad_value),
    .in_new_step       (in_new_step),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_updated_param (out_updated_param),
    .out_index         (out_index)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point helpers of the predictor
  // ---------------------------------------------------------------------------

  // Clamp a wide signed sum to the signed 32-bit range.
  function automatic logic signed [VAL_W-1:0] clamp_q16(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[VAL_W-1:0];
  endfunction

  // Q0.16 rate times a Q16.16 value; the arithmetic shift floors toward minus infinity.
  function automatic logic signed [63:0] scale_by_rate(input logic [RATE_W-1:0] rate,
                                                       input logic signed [63:0] v);
    logic signed [63:0] p;
    p = $signed({48'd0, rate}) * v;
    return p >>> FRAC_W;
  endfunction

  // Linear decay of beta toward its end value; the span reached or empty pins it there.
  function automatic void relatch_beta();
    longint unsigned diff;
    longint unsigned delta;
    if (span_steps == '0 || sched_step >= span_steps) begin
      sched_beta = beta_to;
      return;
    end
    diff  = (beta_from >= beta_to) ? longint'(beta_from - beta_to)
                                   : longint'(beta_to - beta_from);
    delta = (diff * longint'(sched_step)) / longint'(span_steps);
    if (beta_from >= beta_to) sched_beta = beta_from - delta[RATE_W-1:0];
    else sched_beta = beta_from + delta[RATE_W-1:0];
  endfunction

  // Advance the shadow state by one request and return the update it produces.
  function automatic update_t compute_update(input request_t rq);
    update_t            res;
    logic signed [63:0] g;
    logic signed [63:0] m;
    logic               in_store;
    if (rq.new_step) begin
      if (sched_step != STEP_MAX) sched_step = sched_step + 1'b1;
      relatch_beta();
    end
    g = 64'(rq.grad);
    if (wd_rate != '0) g = 64'(clamp_q16(g + scale_by_rate(wd_rate, 64'(rq.param))));
    in_store = (int'(rq.index) < NUM_ELEMENTS);
    m = 0;
    if (in_store) m = 64'(velocity[rq.index]);
    m = 64'(clamp_q16(scale_by_rate(sched_beta, m) + g));
    if (in_store) velocity[rq.index] = m[VAL_W-1:0];
    res.value = clamp_q16(64'(rq.param) - scale_by_rate(lr_rate, m));
    res.index = rq.index;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------

  // Mostly back-to-back, sometimes a few cycles, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // Signed Q16.16 operand: extremes, full-range noise, or moderate magnitudes that
  // keep the arithmetic away from saturation.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
    endcase
  endfunction

  // Register data with random upper bits so that the truncation of narrow registers is hit.
  function automatic logic [CFG_DATA_W-1:0] pick_rate();
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 5))
      0: d[RATE_W-1:0] = '0;
      1: d[RATE_W-1:0] = '1;
      default: ;
    endcase
    return d;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_span();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 24'd1;
      2: return STEP_MAX;
      3, 4, 5: return CFG_DATA_W'($urandom_range(1, 40));
      default: return CFG_DATA_W'($urandom_range(41, 2000));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Write one register while the block is idle and mirror it into the shadow copy.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_LEARNING_RATE: lr_rate    = data[RATE_W-1:0];
      CFG_BETA_START:    beta_from  = data[RATE_W-1:0];
      CFG_BETA_END:      beta_to    = data[RATE_W-1:0];
      CFG_DECAY_SPAN:    span_steps = data[SPAN_W-1:0];
      CFG_DECAY_RATE:    wd_rate    = data[RATE_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one request and hold it until taken. Valid stays high into the next request
  // when no gap follows, so it is only lowered where a gap is inserted.
  task automatic send_request(input logic [IDX_W-1:0] idx, input logic signed [VAL_W-1:0] p,
                              input logic signed [VAL_W-1:0] g, input logic step);
    request_t rq;
    int       gap;
    rq.index    = idx;
    rq.param    = p;
    rq.grad     = g;
    rq.new_step = step;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_element_index <= rq.index;
    in_param_value   <= rq.param;
    in_grad_value    <= rq.grad;
    in_new_step      <= rq.new_step;
    do @(posedge clk); while (in_stall);
    pending_updates.push_back(compute_update(rq));
  endtask

  // Drop valid and wait until every predicted update has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin
    update_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_updates.size() == 0) begin
        report_mismatch("unexpected result, index", longint'(out_index), -1);
      end else begin
        want = pending_updates.pop_front();
        if (out_updated_param !== want.value)
          report_mismatch($sformatf("updated_param of index %0d", want.index),
                          longint'(out_updated_param), longint'(want.value));
        if (out_index !== want.index)
          report_mismatch("out_index", longint'(out_index), longint'(want.index));
      end
    end
  end

  // Result-side stalls: random bursts, or one long hold-off when asked for.
  initial begin : result_stall_gen
    int n;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        n = 1 + pick_gap();
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Abandon the run when neither channel moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: operand extremes, both ends of the index range, repeated indexes.
  task automatic test_reset_settings();
    send_request(12'd0,    32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    send_request(12'd0,    32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_request(12'd4095, 32'sd0,         32'sh7FFF_FFFF, 1'b1);
    send_request(12'd4095, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0);
    send_request(12'd1,    -32'sd1,        32'sd1,         1'b0);
    send_request(12'd1,    32'sd1,         -32'sd1,        1'b0);
  endtask

  // Every register at an extreme, unknown indexes ignored, and beta changing only
  // at the next request that opens a step.
  task automatic test_register_writes();
    int k;
    wait_for_results();
    write_reg(CFG_LEARNING_RATE, 24'hFF_FFFF);
    write_reg(CFG_BETA_START,    24'h00_0000);
    write_reg(CFG_BETA_END,      24'hFF_FFFF);
    write_reg(CFG_DECAY_SPAN,    STEP_MAX);
    write_reg(CFG_DECAY_RATE,    24'hFF_FFFF);
    for (k = int'(CFG_DECAY_RATE) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(k[CFG_IDX_W-1:0], 24'hFF_FFFF);
    send_request(12'd0, 32'sh0001_0000, 32'sh0000_8000, 1'b0);
    send_request(12'd0, 32'sh0001_0000, 32'sh0000_8000, 1'b1);
    wait_for_results();
    write_reg(CFG_BETA_START, 24'h00_FFFF);
    write_reg(CFG_BETA_END,   24'h00_0000);
    send_request(12'd2, -32'sh0002_0000, 32'sh0001_0000, 1'b0);
    send_request(12'd2, -32'sh0002_0000, 32'sh0001_0000, 1'b1);
  endtask

  // Empty decay span, a span of one, and the step counter walking up to the span.
  task automatic test_decay_span_limits();
    wait_for_results();
    write_reg(CFG_LEARNING_RATE, 24'd16384);
    write_reg(CFG_DECAY_RATE,    24'd0);
    write_reg(CFG_DECAY_SPAN,    24'd0);
    send_request(12'd3, 32'sh0004_0000, 32'sh0001_0000, 1'b1);
    wait_for_results();
    write_reg(CFG_DECAY_SPAN, 24'd1);
    send_request(12'd3, 32'sh0004_0000, 32'sh0001_0000, 1'b1);
    wait_for_results();
    write_reg(CFG_DECAY_SPAN, sched_step + 24'd2);
    send_request(12'd3, 32'sh0004_0000, -32'sh0001_0000, 1'b1);
    send_request(12'd3, 32'sh0004_0000, -32'sh0001_0000, 1'b1);
    send_request(12'd3, 32'sh0004_0000, -32'sh0001_0000, 1'b1);
  endtask

  // Full-strength weight decay against parameter extremes.
  task automatic test_weight_decay();
    wait_for_results();
    write_reg(CFG_DECAY_RATE,    24'h00_FFFF);
    write_reg(CFG_LEARNING_RATE, 24'd32768);
    send_request(12'd10, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
    send_request(12'd11, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_request(12'd12, 32'sd0,         32'sh0000_1234, 1'b0);
    send_request(12'd13, -32'sd1,        32'sd0,         1'b0);
    send_request(12'd10, 32'sh0000_0003, -32'sh0000_0007, 1'b0);
  endtask

  // Beta that grows from start to end over a short span.
  task automatic test_rising_beta();
    wait_for_results();
    write_reg(CFG_DECAY_RATE, 24'd0);
    write_reg(CFG_BETA_START, 24'd1000);
    write_reg(CFG_BETA_END,   24'd60000);
    write_reg(CFG_DECAY_SPAN, sched_step + 24'd10);
    send_request(12'd20, 32'sh0001_0000, 32'sh0000_4000, 1'b1);
    send_request(12'd20, 32'sh0001_0000, 32'sh0000_4000, 1'b1);
    send_request(12'd20, 32'sh0001_0000, 32'sh0000_4000, 1'b1);
  endtask

  // Optimizer steps over a few index windows so momentum builds up across steps, with
  // some lone requests, missing step flags and stray flags mixed in. Each phase runs
  // under fresh register settings; the first two use the extremes.
  task automatic test_random_steps();
    int                phase;
    int                sent;
    int                len;
    int                j;
    logic [IDX_W-1:0]  windows [4];
    logic [IDX_W-1:0]  base;
    logic              flag;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_results();
      case (phase)
        0: begin
          write_reg(CFG_LEARNING_RATE, 24'hFF_FFFF);
          write_reg(CFG_BETA_START,    24'hFF_FFFF);
          write_reg(CFG_BETA_END,      24'h00_0000);
          write_reg(CFG_DECAY_SPAN,    24'd1);
          write_reg(CFG_DECAY_RATE,    24'hFF_FFFF);
        end
        1: begin
          write_reg(CFG_LEARNING_RATE, 24'h00_0000);
          write_reg(CFG_BETA_START,    24'h00_0000);
          write_reg(CFG_BETA_END,      24'h00_0000);
          write_reg(CFG_DECAY_SPAN,    STEP_MAX);
          write_reg(CFG_DECAY_RATE,    24'h00_0000);
        end
        default: begin
          write_reg(CFG_LEARNING_RATE, pick_rate());
          write_reg(CFG_BETA_START,    pick_rate());
          write_reg(CFG_BETA_END,      pick_rate());
          write_reg(CFG_DECAY_SPAN,    pick_span());
          write_reg(CFG_DECAY_RATE,    pick_rate());
        end
      endcase
      // Phase 1 runs with no idling on either side.
      gaps_on   = (phase != 1);
      stall_pct = (phase == 1) ? 0 : $urandom_range(5, 50);
      foreach (windows[w]) windows[w] = IDX_W'($urandom_range(0, NUM_ELEMENTS - 1));
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          send_request(IDX_W'($urandom_range(0, NUM_ELEMENTS - 1)), pick_value(),
                       pick_value(), ($urandom_range(0, 1) == 1));
          sent++;
        end else begin
          len  = $urandom_range(1, 12);
          base = windows[2'($urandom_range(0, 3))];
          for (j = 0; j < len; j++) begin
            // Open the step on its first element, now and then forget to.
            flag = (j == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
            send_request(base + IDX_W'(j), pick_value(), pick_value(), flag);
          end
          sent += len;
        end
      end
    end
  endtask

  // Hold the result side for a long stretch while requests keep coming, so the block
  // fills and stalls its input; then pause the sender until everything is back.
  task automatic test_result_backpressure();
    int j;
    wait_for_results();
    stall_pct    = 0;
    gaps_on      = 1'b0;
    hold_results = 1'b1;
    for (j = 0; j < 24; j++)
      send_request(IDX_W'(j % 4), pick_value(), pick_value(), (j % 8) == 0);
    wait_for_results();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    in_valid         <= 1'b0;
    in_element_index <= '0;
    in_param_value   <= '0;
    in_grad_value    <= '0;
    in_new_step      <= 1'b0;
    gaps_on          = 1'b1;
    stall_pct        = 20;
    hold_results     = 1'b0;
    mismatch_count   = 0;

    // Shadow state after reset: register defaults, step zero, momentum cleared.
    lr_rate    = LR_RST;
    beta_from  = BETA_START_RST;
    beta_to    = BETA_END_RST;
    span_steps = SPAN_RST;
    wd_rate    = DECAY_RST;
    sched_step = '0;
    sched_beta = BETA_START_RST;
    foreach (velocity[i]) velocity[i] = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The clearing pass keeps in_stall high; the first request simply waits it out.
    test_reset_settings();
    test_register_writes();
    test_decay_span_limits();
    test_weight_decay();
    test_rising_beta();
    test_random_steps();
    test_result_backpressure();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_updates.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
